>>> rtl/core/dnf_pkg.sv
// Shared constants and the tanh lookup table for the dense neuron datapath.
// No dependencies. The table is computed at elaboration by integer-only
// constant functions.
package dnf_pkg;

   localparam int DATA_WIDTH   = 16;
   localparam int ACC_WIDTH    = 40;
   localparam int FRAC         = DATA_WIDTH - 4;
   localparam int PROD_WIDTH   = 2 * DATA_WIDTH;
   localparam int TANH_DEPTH   = 256;
   localparam int TANH_IDX_W   = $clog2(TANH_DEPTH);
   localparam int TANH_SHIFT   = DATA_WIDTH - 1 - TANH_IDX_W;
   localparam int MODE_WIDTH   = 2;

   // Activation select codes; the unused code behaves as linear.
   localparam logic [MODE_WIDTH-1:0] ACT_LINEAR = 2'd0;
   localparam logic [MODE_WIDTH-1:0] ACT_RELU   = 2'd1;
   localparam logic [MODE_WIDTH-1:0] ACT_TANH   = 2'd2;

   localparam logic [63:0] Q30      = 64'd1 << 30;
   localparam logic [63:0] EINV_Q30 = 64'd395007542;

   typedef logic [TANH_DEPTH-1:0][DATA_WIDTH-1:0] tanh_rom_type;

   // Restoring long division, used only while the table is elaborated.
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-y) in Q30 for y in Q30: Taylor series on the fraction, then one
   // multiplication by exp(-1) for every whole unit.
   function automatic logic [63:0] exp_neg_q30(logic [63:0] y);
      logic [63:0] whole;
      logic [63:0] frac_part;
      logic [63:0] sum;
      logic [63:0] term;
      logic        done;
      whole     = y >> 30;
      frac_part = y & (Q30 - 64'd1);
      sum       = Q30;
      term      = Q30;
      done      = 1'b0;
      for (int k = 1; k <= 24; k++) begin
         if (!done) begin
            term = udiv64((term * frac_part) >> 30, 64'(k));
            if (term == 64'd0) begin
               done = 1'b1;
            end else if (k % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
      end
      for (int j = 0; j < 64; j++) begin
         if (64'(j) < whole) begin
            sum = (sum * EINV_Q30) >> 30;
         end
      end
      return sum;
   endfunction

   // Entry i holds tanh(i * 8 / TANH_DEPTH) with FRAC fraction bits.
   function automatic tanh_rom_type build_tanh_rom();
      tanh_rom_type rom;
      logic [63:0]  y;
      logic [63:0]  e;
      logic [63:0]  num;
      logic [63:0]  den;
      for (int i = 0; i < TANH_DEPTH; i++) begin
         y      = udiv64(64'(i) << 34, 64'(TANH_DEPTH));
         e      = exp_neg_q30(y);
         num    = Q30 - e;
         den    = Q30 + e;
         rom[i] = DATA_WIDTH'(udiv64((num << FRAC) + (den >> 1), den));
      end
      return rom;
   endfunction

   localparam tanh_rom_type TANH_ROM = build_tanh_rom();

endpackage

>>> rtl/core/dense_neuron_forward.sv
// Dense layer neuron: multiply-accumulate over a row, bias, rounding,
// saturation and activation (linear, ReLU or table tanh).
// Depends on dnf_pkg for widths, activation codes and the tanh table.
//
// Usage: each request word carries an input value, its weight, the bias and
// a last-of-row flag. Words are taken at a clock edge where req_valid is high
// and req_stall is low. Words without the last flag only accumulate. The
// last word of a row yields one response word: the rounded, saturated
// pre-activation sum, its activated value and a flag that tells whether any
// clipping happened anywhere in that row.
// Throughput: one request word per cycle while req_stall is low; the last word
// of a row passes the input register, product register, accumulator, rounding
// stage and output register before its response is valid.
// When rsp_stall holds a valid response, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped.
// The user must write the activation mode through csr_wr_en/csr_wr_data only
// while idle; the block does not enforce this. Synchronous reset empties the
// pipeline, clears the accumulator and clip flag and selects linear activation.
module dense_neuron_forward (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [dnf_pkg::DATA_WIDTH-1:0] req_in_value,
   input  logic signed [dnf_pkg::DATA_WIDTH-1:0] req_weight,
   input  logic signed [dnf_pkg::DATA_WIDTH-1:0] req_bias,
   input  logic                                  req_last_in_row,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dnf_pkg::DATA_WIDTH-1:0] rsp_pre_activation,
   output logic signed [dnf_pkg::DATA_WIDTH-1:0] rsp_activated,
   output logic                                  rsp_saturated,
   input  logic                                  csr_wr_en,
   input  logic        [dnf_pkg::MODE_WIDTH-1:0] csr_wr_data
);
   import dnf_pkg::*;

   typedef struct packed {
      logic                        clip;
      logic signed [ACC_WIDTH-1:0] sum;
   } acc_sat_type;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] D_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] D_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1) << (FRAC - 1);
   localparam int HI_W = ACC_WIDTH - DATA_WIDTH + 1;

   function automatic acc_sat_type sat_add(logic signed [ACC_WIDTH-1:0] a,
                                           logic signed [ACC_WIDTH-1:0] b);
      acc_sat_type        res;
      logic [ACC_WIDTH:0] wide;
      wide     = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
      res.clip = wide[ACC_WIDTH] != wide[ACC_WIDTH-1];
      if (res.clip) begin
         res.sum = wide[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         res.sum = wide[ACC_WIDTH-1:0];
      end
      return res;
   endfunction

   logic advance;

   // Stage 1: input register
   logic                         v1_ff, v1_in;
   logic signed [DATA_WIDTH-1:0] x1_ff, w1_ff, b1_ff;
   logic                         last1_ff;

   // Stage 2: product register
   logic                         v2_ff, v2_in;
   logic signed [PROD_WIDTH-1:0] prod2_ff, prod2_in;
   logic signed [DATA_WIDTH-1:0] b2_ff;
   logic                         last2_ff;

   // Stage 3: accumulator and finished row sum
   logic signed [ACC_WIDTH-1:0]  acc_ff, acc_in;
   logic                         sticky_ff, sticky_in;
   logic                         v3_ff, v3_in;
   logic signed [ACC_WIDTH-1:0]  sum3_ff, sum3_in;
   logic                         clip3_ff, clip3_in;
   logic signed [DATA_WIDTH-1:0] b3_ff;
   acc_sat_type                  acc_step;

   // Stage 4: rounded and clipped pre-activation
   logic                         v4_ff, v4_in;
   logic signed [DATA_WIDTH-1:0] p4_ff, p4_in;
   logic                         clip4_ff, clip4_in;
   acc_sat_type                  bias_step, round_step;
   logic signed [ACC_WIDTH-1:0]  bias_ext;
   logic signed [ACC_WIDTH-1:0]  p_wide;
   logic        [HI_W-1:0]       p_hi;

   // Stage 5: output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_pre_ff, rsp_act_ff, act_in;
   logic                         rsp_sat_ff;
   logic [MODE_WIDTH-1:0]        mode_ff, mode_in;
   logic [DATA_WIDTH-1:0]        mag;
   logic [TANH_IDX_W:0]          idx_full;
   logic [TANH_IDX_W-1:0]        idx;
   logic signed [DATA_WIDTH-1:0] tanh_val;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign v1_in    = req_valid;
   assign v2_in    = v1_ff;
   assign prod2_in = x1_ff * w1_ff;
   assign mode_in  = csr_wr_en ? csr_wr_data : mode_ff;

   // Accumulate; the last word of a row hands its sum on and clears the state.
   always_comb begin
      acc_step  = sat_add(acc_ff, ACC_WIDTH'(prod2_ff));
      acc_in    = acc_ff;
      sticky_in = sticky_ff;
      v3_in     = 1'b0;
      sum3_in   = acc_step.sum;
      clip3_in  = sticky_ff | acc_step.clip;
      if (v2_ff) begin
         if (last2_ff) begin
            acc_in    = '0;
            sticky_in = 1'b0;
            v3_in     = 1'b1;
         end else begin
            acc_in    = acc_step.sum;
            sticky_in = sticky_ff | acc_step.clip;
         end
      end
   end

   // Bias, round half up, then floor shift and clip to the data width.
   always_comb begin
      bias_ext   = ACC_WIDTH'(b3_ff) <<< FRAC;
      bias_step  = sat_add(sum3_ff, bias_ext);
      round_step = sat_add(bias_step.sum, ROUND_HALF);
      p_wide     = round_step.sum >>> FRAC;
      p_hi       = p_wide[ACC_WIDTH-1:DATA_WIDTH-1];
      clip4_in   = clip3_ff | bias_step.clip | round_step.clip;
      p4_in      = p_wide[DATA_WIDTH-1:0];
      if (p_hi != '0 && p_hi != '1) begin
         clip4_in = 1'b1;
         p4_in    = p_wide[ACC_WIDTH-1] ? D_MIN : D_MAX;
      end
      v4_in = v3_ff;
   end

   // Activation on the pre-activation value.
   always_comb begin
      mag      = p4_ff[DATA_WIDTH-1] ? (~p4_ff + DATA_WIDTH'(1)) : p4_ff;
      idx_full = mag[DATA_WIDTH-1:TANH_SHIFT];
      idx      = idx_full[TANH_IDX_W] ? '1 : idx_full[TANH_IDX_W-1:0];
      tanh_val = p4_ff[DATA_WIDTH-1] ? -$signed(TANH_ROM[idx]) : $signed(TANH_ROM[idx]);
      unique case (mode_ff)
         ACT_RELU: begin
            act_in = (p4_ff > 0) ? p4_ff : '0;
         end
         ACT_TANH: begin
            act_in = tanh_val;
         end
         default: begin
            act_in = p4_ff;
         end
      endcase
      rsp_valid_in = v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         sticky_ff    <= 1'b0;
         mode_ff      <= ACT_LINEAR;
      end else begin
         mode_ff <= mode_in;
         if (advance) begin
            v1_ff        <= v1_in;
            v2_ff        <= v2_in;
            v3_ff        <= v3_in;
            v4_ff        <= v4_in;
            rsp_valid_ff <= rsp_valid_in;
            acc_ff       <= acc_in;
            sticky_ff    <= sticky_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff      <= req_in_value;
         w1_ff      <= req_weight;
         b1_ff      <= req_bias;
         last1_ff   <= req_last_in_row;
         prod2_ff   <= prod2_in;
         b2_ff      <= b1_ff;
         last2_ff   <= last1_ff;
         sum3_ff    <= sum3_in;
         clip3_ff   <= clip3_in;
         b3_ff      <= b2_ff;
         p4_ff      <= p4_in;
         clip4_ff   <= clip4_in;
         rsp_pre_ff <= p4_ff;
         rsp_act_ff <= act_in;
         rsp_sat_ff <= clip4_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pre_activation = rsp_pre_ff;
   assign rsp_activated      = rsp_act_ff;
   assign rsp_saturated      = rsp_sat_ff;

endmodule
